// ===== rtl/core/mpit_pkg.sv =====
// ----------------------------------------------------------------------------
// mpit_pkg: shared types and constants
// kinds, register indexes and sizes of the performance intent tracker
// ----------------------------------------------------------------------------
package mpit_pkg;

  localparam int OnsetDepth  = 64;
  localparam int OnsetAw     = $clog2(OnsetDepth);
  localparam int ClassWindow = 8;
  localparam int ClassAw     = $clog2(ClassWindow);

  typedef enum logic [2:0] {
    KIND_GTR_ON  = 3'd0,
    KIND_GTR_OFF = 3'd1,
    KIND_CC2     = 3'd2,
    KIND_VOX_ON  = 3'd3,
    KIND_VOX_OFF = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_WINDOW  = 3'd0,
    REG_SILENCE = 3'd1,
    REG_FLOOR   = 3'd2,
    REG_RATE    = 3'd3,
    REG_CENTER  = 3'd4,
    REG_PEAK    = 3'd5,
    REG_RATIO   = 3'd6,
    REG_MASK    = 3'd7
  } reg_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic event_upd; // apply non-query event
    logic ring_push; // append onset time and class
    logic trim_step; // drop oldest onset
    logic scan_init; // start query scan
    logic scan_step; // examine one onset and one class
    logic mul_step;  // register products
    logic finish;    // compute flags into output register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic is_new_onset;
    logic trim_more;
    logic scan_done;
  } stat_t;

endpackage

// ===== rtl/core/mpit_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpit_ctrl: sequencer
// steps one item through load, then update and trim, or scan, products and result
// ----------------------------------------------------------------------------
module mpit_ctrl import mpit_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_TRIM, ST_SCAN, ST_MUL, ST_WAIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_query) begin
          ctrl_o.scan_init = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          ctrl_o.event_upd = 1'b1;
          if (stat_i.is_new_onset) begin
            ctrl_o.ring_push = 1'b1;
            state_d          = ST_TRIM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TRIM: begin
        if (stat_i.trim_more) ctrl_o.trim_step = 1'b1;
        else state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_d = ST_MUL;
        else ctrl_o.scan_step = 1'b1;
      end
      ST_MUL: begin
        ctrl_o.mul_step = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/mpit_dp.sv =====
// ----------------------------------------------------------------------------
// mpit_dp: datapath
// tracker state, onset ring memory, class ring, query scan and flags
// ----------------------------------------------------------------------------
module mpit_dp import mpit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output stat_t       stat_o,
  input  logic [2:0]  kind_i,
  input  logic [6:0]  note_i,
  input  logic [6:0]  value_i,
  input  logic [31:0] ts_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        out_pop_i,
  output logic        out_valid_o,
  output logic [6:0]  o_vel_o,
  output logic [6:0]  o_breath_o,
  output logic [6:0]  o_center_o,
  output logic [31:0] o_eg_o,
  output logic [31:0] o_ea_o,
  output logic [7:0]  o_voice_o,
  output logic [31:0] o_ev_o,
  output logic [6:0]  o_count_o,
  output logic [3:0]  o_outc_o,
  output logic [3:0]  o_pcc_o,
  output logic [6:0]  o_flags_o
);

  // configuration
  logic [15:0] win_q, sil_q, rate_q;
  logic [6:0]  floor_q, hic_q, peak_q;
  logic [8:0]  ratio_q;
  logic [11:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 16'd1000; sil_q <= 16'd1000; floor_q <= 7'd20; rate_q <= 16'd1536;
      hic_q <= 7'd72; peak_q <= 7'd100; ratio_q <= 9'd128; mask_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_WINDOW:  win_q   <= cfg_data_i;
        REG_SILENCE: sil_q   <= cfg_data_i;
        REG_FLOOR:   floor_q <= cfg_data_i[6:0];
        REG_RATE:    rate_q  <= cfg_data_i;
        REG_CENTER:  hic_q   <= cfg_data_i[6:0];
        REG_PEAK:    peak_q  <= cfg_data_i[6:0];
        REG_RATIO:   ratio_q <= cfg_data_i[8:0];
        REG_MASK:    mask_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic [15:0] w_eff, s_eff;
  assign w_eff = (win_q == '0) ? 16'd1 : win_q;
  assign s_eff = (sil_q == '0) ? 16'd1 : sil_q;

  // captured item
  kind_e       kind_q;
  logic [6:0]  note_q, value_q;
  logic [31:0] ts_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      kind_q <= kind_e'(kind_i); note_q <= note_i; value_q <= value_i; ts_q <= ts_i;
    end
  end

  // tracker state
  logic [127:0] held_q;
  logic [6:0]   vel_q, breath_q, center_q;
  logic [7:0]   voice_q;
  logic         gv_q, av_q, vv_q;
  logic [31:0]  gt_q, at_q, vt_q;
  logic [OnsetAw-1:0] ohead_q;
  logic [OnsetAw:0]   ofill_q;
  logic [ClassAw-1:0] chead_q;
  logic [ClassAw:0]   cfill_q;
  logic [3:0]   cring_q [ClassWindow];
  logic [31:0]  oring_q [OnsetDepth];

  logic [9:0] cen_num;
  logic [6:0] cen_new;
  logic [3:0] pc_new;
  logic [14:0] pc_mul;
  logic [3:0]  pc_quo;
  assign cen_num = {1'b0, center_q, 2'b00} + {3'b000, note_q} + 10'd2;
  assign cen_new = 7'((20'(cen_num) * 20'd205) >> 10); // exact for < 1024 range used
  // note / 12 by reciprocal multiply, exact for notes 0..127
  assign pc_mul  = {8'd0, note_q} * 15'd171;
  assign pc_quo  = pc_mul[14:11];
  assign pc_new  = 4'(note_q - {pc_quo, 3'b000} - {1'b0, pc_quo, 2'b00});

  logic new_onset;
  assign new_onset = (kind_q == KIND_GTR_ON) && !held_q[note_q];

  // trim check uses registered read of the head entry
  logic [31:0] head_rd_q;
  logic [OnsetAw-1:0] rd_addr;
  logic [OnsetAw-1:0] scan_addr;
  logic [OnsetAw:0]   scan_k_q;
  logic               trim_chk_q;

  logic [OnsetAw-1:0] push_head, push_addr;
  logic [OnsetAw:0]   push_fill;
  assign push_head = (ofill_q == (OnsetAw+1)'(OnsetDepth)) ? ohead_q + 1'b1 : ohead_q;
  assign push_fill = (ofill_q == (OnsetAw+1)'(OnsetDepth)) ? ofill_q : ofill_q + 1'b1;
  assign push_addr = push_head + OnsetAw'(push_fill - 1'b1);
  assign scan_addr = ohead_q + OnsetAw'(scan_k_q - 1'b1);

  always_comb begin
    rd_addr = ohead_q;
    if (ctrl_i.scan_step) rd_addr = scan_addr;
    else if (ctrl_i.trim_step) rd_addr = ohead_q + 1'b1;
    else if (ctrl_i.ring_push) rd_addr = push_head;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ring_push) oring_q[push_addr] <= ts_q;
    head_rd_q <= (ctrl_i.ring_push && push_addr == rd_addr) ? ts_q : oring_q[rd_addr];
  end

  logic head_old;
  assign head_old = ({1'b0, head_rd_q} + 33'(w_eff)) < {1'b0, ts_q};
  assign stat_o.trim_more   = trim_chk_q && (ofill_q != '0) && head_old;
  assign stat_o.is_query    = (kind_q == KIND_QUERY);
  assign stat_o.is_new_onset = new_onset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0; vel_q <= '0; breath_q <= '0; center_q <= 7'd60; voice_q <= 8'hFF;
      gv_q <= 1'b0; av_q <= 1'b0; vv_q <= 1'b0;
      gt_q <= '0; at_q <= '0; vt_q <= '0;
      ohead_q <= '0; ofill_q <= '0; chead_q <= '0; cfill_q <= '0;
      trim_chk_q <= 1'b0;
    end else begin
      trim_chk_q <= ctrl_i.ring_push || ctrl_i.trim_step;
      if (ctrl_i.trim_step) begin
        ohead_q <= ohead_q + 1'b1;
        ofill_q <= ofill_q - 1'b1;
      end
      if (ctrl_i.event_upd) begin
        case (kind_q)
          KIND_GTR_ON: begin
            vel_q <= value_q;
            if (new_onset) begin
              held_q[note_q] <= 1'b1;
              gv_q <= 1'b1; gt_q <= ts_q; av_q <= 1'b1; at_q <= ts_q;
              center_q <= cen_new;
            end
          end
          KIND_GTR_OFF: held_q[note_q] <= 1'b0;
          KIND_CC2: begin
            breath_q <= value_q;
            if (value_q >= floor_q) begin
              av_q <= 1'b1; at_q <= ts_q;
            end
          end
          KIND_VOX_ON: begin
            voice_q <= {1'b0, note_q}; vv_q <= 1'b1; vt_q <= ts_q;
            av_q <= 1'b1; at_q <= ts_q;
          end
          default: ;
        endcase
      end
      if (ctrl_i.ring_push) begin
        ohead_q <= push_head;
        ofill_q <= push_fill;
        if (cfill_q == (ClassAw+1)'(ClassWindow)) chead_q <= chead_q + 1'b1;
        else cfill_q <= cfill_q + 1'b1;
      end
    end
  end

  logic [ClassAw-1:0] cpush_addr;
  assign cpush_addr = (cfill_q == (ClassAw+1)'(ClassWindow)) ? chead_q :
                      chead_q + ClassAw'(cfill_q);
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ring_push) cring_q[cpush_addr] <= pc_new;
  end

  // query scan: one onset entry and one class entry per step
  logic [6:0]  count_q;
  logic [3:0]  outc_q;
  logic [ClassAw:0] ck_q;
  logic        stop_q, rd_ok_q;
  logic        odone, cdone;
  assign odone = stop_q || (scan_k_q == '0 && !rd_ok_q);
  assign cdone = (ck_q == cfill_q);
  assign stat_o.scan_done = odone && cdone && !rd_ok_q;

  logic [3:0] pc_rd;
  assign pc_rd = cring_q[chead_q + ClassAw'(ck_q)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; outc_q <= '0; ck_q <= '0; scan_k_q <= '0;
      stop_q <= 1'b0; rd_ok_q <= 1'b0;
    end else if (ctrl_i.scan_init) begin
      count_q <= '0; outc_q <= '0; ck_q <= '0; scan_k_q <= ofill_q;
      stop_q <= 1'b0; rd_ok_q <= 1'b0;
    end else if (ctrl_i.scan_step) begin
      // evaluate the entry read last cycle
      if (rd_ok_q && !stop_q) begin
        if (({1'b0, head_rd_q} + 33'(w_eff)) < {1'b0, ts_q}) stop_q <= 1'b1;
        else count_q <= count_q + 1'b1;
      end
      if (!stop_q && scan_k_q != '0 &&
          !(rd_ok_q && ({1'b0, head_rd_q} + 33'(w_eff)) < {1'b0, ts_q})) begin
        scan_k_q <= scan_k_q - 1'b1;
        rd_ok_q  <= 1'b1;
      end else begin
        rd_ok_q <= 1'b0;
      end
      if (!cdone) begin
        ck_q <= ck_q + 1'b1;
        if (!mask_q[pc_rd]) outc_q <= outc_q + 1'b1;
      end
    end
  end

  // products, registered before compare
  logic [31:0] rw_q;        // rate * window
  logic [24:0] c256k_q;     // count * 256000
  logic [31:0] c25m_q;      // count * 25600000
  logic [12:0] o256_q;
  logic [12:0] rfill_q;
  logic [32:0] eg_q, ea_q, ev_q;

  function automatic logic [32:0] elap(input logic v, input logic [31:0] t,
                                       input logic [31:0] now);
    if (!v) elap = {1'b1, 32'hFFFF_FFFF};
    else if (now >= t) elap = {1'b0, now - t};
    else elap = '0;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_step) begin
      rw_q    <= 32'(rate_q) * 32'(w_eff);
      c256k_q <= 25'(count_q) * 25'd256000;
      c25m_q  <= 32'(count_q) * 32'd25600000;
      o256_q  <= {1'b0, outc_q, 8'd0};
      rfill_q <= 13'(ratio_q) * 13'(cfill_q);
      eg_q <= elap(gv_q, gt_q, ts_q);
      ea_q <= elap(av_q, at_q, ts_q);
      ev_q <= elap(vv_q, vt_q, ts_q);
    end
  end

  logic [37:0] rw45;
  assign rw45 = 38'(rw_q) * 38'd45; // constant multiply, shifts and adds
  logic sil, dens, regh, pk, outs, sons, act;
  logic [6:0] floor2;
  assign floor2 = (peak_q >= 7'd18) ? peak_q - 7'd18 : 7'd0;
  assign sil  = ea_q >= 33'(s_eff);
  assign dens = !sil && (32'(c256k_q) >= rw_q);
  assign regh = !sil && (center_q >= hic_q);
  assign pk   = !sil && (breath_q >= peak_q);
  assign outs = !sil && (mask_q != '0) && (cfill_q != '0) && (o256_q >= rfill_q);
  assign sons = sil && (ea_q <= 33'(s_eff) + 33'd260);
  assign act  = (38'(c25m_q) >= rw45) || (eg_q <= 33'd900) || (breath_q >= floor2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (ctrl_i.finish) out_valid_o <= 1'b1;
    else if (out_pop_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      o_vel_o    <= vel_q;
      o_breath_o <= breath_q;
      o_center_o <= center_q;
      o_eg_o     <= eg_q[32] ? 32'hFFFF_FFFF : eg_q[31:0];
      o_ea_o     <= ea_q[32] ? 32'hFFFF_FFFF : ea_q[31:0];
      o_ev_o     <= ev_q[32] ? 32'hFFFF_FFFF : ev_q[31:0];
      o_voice_o  <= voice_q;
      o_count_o  <= count_q;
      o_outc_o   <= (mask_q != '0) ? outc_q : 4'd0;
      o_pcc_o    <= 4'(cfill_q);
      o_flags_o  <= {sons && act, sons, outs, pk, regh, dens, sil};
    end
  end

endmodule

// ===== rtl/core/midi_performance_intent_tracker.sv =====
// ----------------------------------------------------------------------------
// midi_performance_intent_tracker: performance intent tracker top level
// stream of midi events and query ticks in, one intent summary per query out
// ----------------------------------------------------------------------------
// One item is handled at a time. A note, cc2 or voice event passes through
// load and decode; a new guitar onset adds a window check plus one trim step
// per onset dropped from the window. A query walks the onset ring newest
// first, one memory read per cycle, with the 8-entry pitch class ring counted
// alongside, then registers the threshold products. The output register
// holds one result; the next item is taken while it waits, but a second
// query waits for the first to be taken.
module midi_performance_intent_tracker import mpit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // note[6:0], value[13:7], timestamp_ms[45:14], zero fill to 48
  input  logic [47:0] s_tdata_i,
  // kind[2:0]
  input  logic [2:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // last_guitar_velocity[6:0], last_breath[13:7], register_center[20:14],
  // ms_since_guitar_onset[52:21], ms_since_activity[84:53],
  // last_voice_note[92:85], ms_since_voice_onset[124:93],
  // notes_in_window[131:125], outside_count[135:132],
  // pitch_class_count[139:136], flags[146:140], zero fill to 152
  output logic [151:0] m_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;
  logic  busy, in_fire, out_pop, out_valid;

  assign s_tready_o = !busy;
  assign in_fire    = s_tvalid_i && s_tready_o;
  assign out_pop    = out_valid && m_tready_i;
  assign m_tvalid_o = out_valid;

  mpit_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .out_free_i (!out_valid || m_tready_i),
    .stat_i     (stat),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  logic [6:0] vel, br, cen, cnt, flg;
  logic [31:0] eg, ea, ev;
  logic [7:0] vox;
  logic [3:0] outc, pcc;

  mpit_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .kind_i     (s_tuser_i),
    .note_i     (s_tdata_i[6:0]),
    .value_i    (s_tdata_i[13:7]),
    .ts_i       (s_tdata_i[45:14]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_pop_i  (out_pop),
    .out_valid_o(out_valid),
    .o_vel_o(vel), .o_breath_o(br), .o_center_o(cen),
    .o_eg_o(eg), .o_ea_o(ea), .o_voice_o(vox), .o_ev_o(ev),
    .o_count_o(cnt), .o_outc_o(outc), .o_pcc_o(pcc), .o_flags_o(flg)
  );

  assign m_tdata_o = {5'd0, flg, pcc, outc, cnt, ev, vox, ea, eg, cen, br, vel};

endmodule

// ===== rtl/core/mpit_checker.sv =====
// ----------------------------------------------------------------------------
// mpit_checker: port checker
// handshake and result sanity checks on the tracker ports
// ----------------------------------------------------------------------------
module mpit_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid_i,
  input logic         s_tready_o,
  input logic         m_tvalid_o,
  input logic         m_tready_i,
  input logic [151:0] m_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result dropped while stalled");

  a_pcc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[139:136] <= 4'd8)
    else $error("pitch class count out of range");

  a_outc_le_pcc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[135:132] <= m_tdata_o[139:136])
    else $error("outside count exceeds pitch class count");

  a_sonset_sil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[145] |-> m_tdata_o[140])
    else $error("silence onset without silence");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("second item taken during work");

endmodule

bind midi_performance_intent_tracker mpit_checker u_mpit_checker (.*);

// ===== test/mpit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpit_scoreboard: intent summary predictor and scoreboard
// watches the event and summary streams, predicts each query summary and
// compares it field by field with what the tracker returns
// ----------------------------------------------------------------------------
module mpit_scoreboard import mpit_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [47:0]  s_tdata_i,
  input  logic [2:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [151:0] m_tdata_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int SumDepth = 16;

  typedef struct packed {
    logic [6:0]  flags;
    logic [3:0]  pc_count;
    logic [3:0]  out_count;
    logic [6:0]  in_window;
    logic [31:0] since_voice;
    logic [7:0]  voice_note;
    logic [31:0] since_activity;
    logic [31:0] since_guitar;
    logic [6:0]  center;
    logic [6:0]  breath;
    logic [6:0]  velocity;
  } summary_t;

  logic [15:0] window_ms, silence_len_ms, rate_q8;
  logic [6:0]  act_floor, high_center, peak_cc2;
  logic [8:0]  ratio_q8;
  logic [11:0] pc_mask;

  logic        held [128];
  logic [6:0]  velocity, breath, center;
  logic [7:0]  voice_note;
  logic        guitar_seen, activity_seen, voice_seen;
  logic [31:0] guitar_ts, activity_ts, voice_ts;
  logic [31:0] onsets [OnsetDepth];
  int          onset_head, onset_count;
  logic [3:0]  classes [ClassWindow];
  int          class_head, class_count;
  summary_t    pend [SumDepth];
  int          pend_rd, pend_count;

  assign pending_o = pend_count;

  function automatic logic [32:0] since(logic seen, logic [31:0] t, logic [31:0] now);
    if (!seen) return 33'h1_0000_0000;
    return (now >= t) ? {1'b0, now - t} : 33'd0;
  endfunction

  function automatic summary_t summarize(logic [31:0] now);
    summary_t    s;
    logic [63:0] w, sil, cnt, outc, eg, ea, ev, floor2;
    logic        silent, sonset, busy;
    w   = (window_ms == 0) ? 64'd1 : 64'(window_ms);
    sil = (silence_len_ms == 0) ? 64'd1 : 64'(silence_len_ms);
    eg  = 64'(since(guitar_seen, guitar_ts, now));
    ea  = 64'(since(activity_seen, activity_ts, now));
    ev  = 64'(since(voice_seen, voice_ts, now));
    cnt = 0;
    outc = 0;
    for (int k = onset_count - 1; k >= 0; k--) begin
      if (64'(onsets[(onset_head + k) % OnsetDepth]) + w < 64'(now)) break;
      cnt++;
    end
    if (pc_mask != 0) begin
      for (int k = 0; k < class_count; k++)
        if (!pc_mask[classes[(class_head + k) % ClassWindow]]) outc++;
    end
    silent = ea >= sil;
    sonset = silent && ea <= sil + 260;
    floor2 = (peak_cc2 >= 18) ? 64'(peak_cc2 - 18) : 64'd0;
    busy = (cnt * 25600000 >= 45 * 64'(rate_q8) * w) || eg <= 900 || 64'(breath) >= floor2;
    s.velocity       = velocity;
    s.breath         = breath;
    s.center         = center;
    s.since_guitar   = (eg > 64'hFFFF_FFFF) ? '1 : eg[31:0];
    s.since_activity = (ea > 64'hFFFF_FFFF) ? '1 : ea[31:0];
    s.voice_note     = voice_note;
    s.since_voice    = (ev > 64'hFFFF_FFFF) ? '1 : ev[31:0];
    s.in_window      = cnt[6:0];
    s.out_count      = outc[3:0];
    s.pc_count       = 4'(class_count);
    s.flags[0] = silent;
    s.flags[1] = !silent && cnt * 256000 >= 64'(rate_q8) * w;
    s.flags[2] = !silent && center >= high_center;
    s.flags[3] = !silent && breath >= peak_cc2;
    s.flags[4] = !silent && pc_mask != 0 && class_count > 0 &&
                 outc * 256 >= 64'(ratio_q8) * 64'(class_count);
    s.flags[5] = sonset;
    s.flags[6] = sonset && busy;
    return s;
  endfunction

  // onset bookkeeping for a key that was not already held
  function automatic void add_onset(logic [6:0] note, logic [31:0] ts);
    logic [63:0] w;
    w = (window_ms == 0) ? 64'd1 : 64'(window_ms);
    held[note] = 1'b1;
    guitar_seen = 1'b1;
    guitar_ts = ts;
    activity_seen = 1'b1;
    activity_ts = ts;
    center = 7'((4 * 32'(center) + 32'(note) + 2) / 5);
    if (onset_count == OnsetDepth) begin
      onset_head = (onset_head + 1) % OnsetDepth;
      onset_count--;
    end
    onsets[(onset_head + onset_count) % OnsetDepth] = ts;
    onset_count++;
    while (onset_count > 0 && 64'(onsets[onset_head]) + w < 64'(ts)) begin
      onset_head = (onset_head + 1) % OnsetDepth;
      onset_count--;
    end
    if (class_count == ClassWindow) begin
      class_head = (class_head + 1) % ClassWindow;
      class_count--;
    end
    classes[(class_head + class_count) % ClassWindow] = 4'(note % 12);
    class_count++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [6:0]  note, val;
    logic [31:0] ts;
    summary_t    got, want;
    if (!rst_ni) begin
      window_ms = 1000; silence_len_ms = 1000; act_floor = 20; rate_q8 = 1536;
      high_center = 72; peak_cc2 = 100; ratio_q8 = 128; pc_mask = 0;
      foreach (held[k]) held[k] = 1'b0;
      velocity = 0; breath = 0; center = 60; voice_note = 8'hFF;
      guitar_seen = 0; activity_seen = 0; voice_seen = 0;
      guitar_ts = 0; activity_ts = 0; voice_ts = 0;
      onset_head = 0; onset_count = 0; class_head = 0; class_count = 0;
      pend_rd = 0; pend_count = 0;
      fail_count_o = 0;
    end else begin
      // result side first: a summary leaving this edge was predicted earlier
      if (m_tvalid_i && m_tready_i) begin
        got = summary_t'(m_tdata_i[146:0]);
        if (pend_count == 0) begin
          $display("%t: unexpected summary transfer expected none actual %h", $time, got);
          fail_count_o++;
        end else begin
          want = pend[pend_rd];
          pend_rd = (pend_rd + 1) % SumDepth;
          pend_count--;
          if (got != want) begin
            $display("%t: summary mismatch expected %p", $time, want);
            $display("%t:                   actual   %p", $time, got);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_WINDOW:  window_ms = cfg_data_i;
          REG_SILENCE: silence_len_ms = cfg_data_i;
          REG_FLOOR:   act_floor = cfg_data_i[6:0];
          REG_RATE:    rate_q8 = cfg_data_i;
          REG_CENTER:  high_center = cfg_data_i[6:0];
          REG_PEAK:    peak_cc2 = cfg_data_i[6:0];
          REG_RATIO:   ratio_q8 = cfg_data_i[8:0];
          REG_MASK:    pc_mask = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        note = s_tdata_i[6:0];
        val  = s_tdata_i[13:7];
        ts   = s_tdata_i[45:14];
        case (s_tuser_i)
          KIND_GTR_ON: begin
            velocity = val;
            if (!held[note]) add_onset(note, ts);
          end
          KIND_GTR_OFF: held[note] = 1'b0;
          KIND_CC2: begin
            breath = val;
            if (val >= act_floor) begin
              activity_seen = 1'b1;
              activity_ts = ts;
            end
          end
          KIND_VOX_ON: begin
            voice_note = {1'b0, note};
            voice_seen = 1'b1;
            voice_ts = ts;
            activity_seen = 1'b1;
            activity_ts = ts;
          end
          KIND_QUERY: begin
            if (pend_count == SumDepth) begin
              $display("%t: too many summaries outstanding expected at most %0d actual %0d",
                       $time, SumDepth, pend_count + 1);
              fail_count_o++;
            end else begin
              pend[(pend_rd + pend_count) % SumDepth] = summarize(ts);
              pend_count++;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb_midi_performance_intent_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_performance_intent_tracker: intent tracker testbench
// directed and random event streams with bursty input and a stalling
// receiver, several register settings; a checker predicts every summary
// ----------------------------------------------------------------------------
module tb_midi_performance_intent_tracker import mpit_pkg::*;;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [47:0]  s_tdata_i = '0;
  logic [2:0]   s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [151:0] m_tdata_o;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;
  int           fail_count;
  int           pending;
  logic         stall_en = 1'b1;

  // event clock of the stimulus, nondecreasing except for deliberate steps back
  logic [31:0]  now_ms = 32'd0;
  int           leftover_stall = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  midi_performance_intent_tracker DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid_i), .s_tready_o(s_tready_o),
    .s_tdata_i(s_tdata_i), .s_tuser_i(s_tuser_i),
    .m_tvalid_o(m_tvalid_o), .m_tready_i(m_tready_i), .m_tdata_o(m_tdata_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  mpit_scoreboard u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid_i), .s_tready_i(s_tready_o),
    .s_tdata_i(s_tdata_i), .s_tuser_i(s_tuser_i),
    .m_tvalid_i(m_tvalid_o), .m_tready_i(m_tready_i), .m_tdata_i(m_tdata_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: stall runs of random length, sometimes long, sometimes none
  always @(posedge clk_i) begin
    if (!stall_en) begin
      m_tready_i <= 1'b1;
    end else if (leftover_stall > 0) begin
      leftover_stall <= leftover_stall - 1;
      m_tready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      leftover_stall <= $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // one input transfer; valid stays up until tready is seen at an edge
  task automatic send(kind_e k, logic [6:0] note, logic [6:0] val, logic [31:0] ts);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= k;
    s_tdata_i  <= {2'b00, ts, val, note};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task automatic pause_input();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // kinds 6 and 7 are outside the enum and must be ignored
  task automatic send_raw(logic [2:0] k, logic [31:0] ts);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= k;
    s_tdata_i  <= {2'b00, ts, 7'($urandom), 7'($urandom)};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // all summaries returned, then enough cycles for a trailing trim pass
  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic program_all(logic [15:0] w, logic [15:0] sil, logic [6:0] fl,
                             logic [15:0] rate, logic [6:0] hc, logic [6:0] pk,
                             logic [8:0] ratio, logic [11:0] mask);
    write_reg(REG_WINDOW, w);
    write_reg(REG_SILENCE, sil);
    write_reg(REG_FLOOR, 16'(fl));
    write_reg(REG_RATE, rate);
    write_reg(REG_CENTER, 16'(hc));
    write_reg(REG_PEAK, 16'(pk));
    write_reg(REG_RATIO, 16'(ratio));
    write_reg(REG_MASK, 16'(mask));
  endtask

  // random item weighted toward playing: phrases of onsets, breath and queries
  task automatic random_item(int step_max);
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0)
      now_ms = now_ms + $urandom_range(1000, 70000);   // long rest
    else if ($urandom_range(0, 99) == 0 && now_ms > 10)
      now_ms = now_ms - $urandom_range(1, 10);         // clock steps back
    else
      now_ms = now_ms + $urandom_range(0, step_max);
    if (pick < 35)      send(KIND_GTR_ON, 7'($urandom), 7'($urandom), now_ms);
    else if (pick < 50) send(KIND_GTR_OFF, 7'($urandom), 7'($urandom), now_ms);
    else if (pick < 60) send(KIND_CC2, 7'($urandom), 7'($urandom), now_ms);
    else if (pick < 67) send(KIND_VOX_ON, 7'($urandom), 7'($urandom), now_ms);
    else if (pick < 70) send(KIND_VOX_OFF, 7'($urandom), 7'($urandom), now_ms);
    else if (pick < 71) send_raw($urandom_range(0, 1) ? 3'd6 : 3'd7, now_ms);
    else                send(KIND_QUERY, 7'($urandom), 7'($urandom), now_ms);
    // bursts with random gaps between them
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 12)) pause_input();
  endtask

  task automatic random_phase(int items, int step_max);
    repeat (items) random_item(step_max);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // queries before anything happened: every elapsed time reads as never
    send(KIND_QUERY, 7'd0, 7'd0, 32'd0);
    send(KIND_VOX_OFF, 7'd127, 7'd127, 32'd5);
    send(KIND_QUERY, 7'd127, 7'd127, 32'hFFFF_FFFF);
    // extremes of notes, velocities and breath
    send(KIND_GTR_ON, 7'd0, 7'd127, 32'd10);
    send(KIND_GTR_ON, 7'd0, 7'd1, 32'd11);             // held key: velocity only
    send(KIND_GTR_ON, 7'd127, 7'd0, 32'd12);
    send(KIND_GTR_OFF, 7'd0, 7'd0, 32'd13);
    send(KIND_GTR_ON, 7'd0, 7'd64, 32'd14);
    send(KIND_CC2, 7'd0, 7'd127, 32'd15);
    send(KIND_CC2, 7'd0, 7'd19, 32'd16);               // below activity floor
    send(KIND_VOX_ON, 7'd127, 7'd50, 32'd20);
    send(KIND_QUERY, 7'd0, 7'd0, 32'd30);
    send(KIND_QUERY, 7'd0, 7'd0, 32'd5);               // time going backwards
    send_raw(3'd6, 32'd40);
    send_raw(3'd7, 32'd41);
    send(KIND_QUERY, 7'd0, 7'd0, 32'd1030);            // silence onset edge
    send(KIND_QUERY, 7'd0, 7'd0, 32'd1300);
    send(KIND_QUERY, 7'd0, 7'd0, 32'hFFFF_FFFF);
    drain();

    // chord mask on, tiny window, zero-valued registers
    program_all(16'd0, 16'd0, 7'd0, 16'd0, 7'd0, 7'd0, 9'd0, 12'hFFF);
    random_phase(250, 3);
    program_all(16'd1000, 16'd1000, 7'd20, 16'd1536, 7'd72, 7'd100, 9'd128, 12'h0AD);
    random_phase(400, 40);
    // widest window: fill the onset ring past its depth
    program_all(16'hFFFF, 16'hFFFF, 7'd127, 16'hFFFF, 7'd127, 7'd127, 9'd256, 12'h001);
    for (int i = 0; i < 80; i++) begin
      now_ms = now_ms + 1;
      send(KIND_GTR_ON, 7'(i), 7'($urandom), now_ms);
      if (i % 16 == 15) send(KIND_QUERY, 7'd0, 7'd0, now_ms);
    end
    for (int i = 0; i < 80; i++) send(KIND_GTR_OFF, 7'(i), 7'd0, now_ms);
    random_phase(350, 200);
    stall_en <= 1'b0;
    program_all(16'(($urandom_range(1, 3000))), 16'($urandom_range(1, 3000)),
                7'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
                9'($urandom_range(0, 256)), 12'($urandom));
    random_phase(400, 20);
    stall_en <= 1'b1;
    program_all(16'd200, 16'd300, 7'd64, 16'h8000, 7'd60, 7'd50, 9'd64, 12'hFFE);
    random_phase(200, 10);

    if (fail_count == 0) begin
      $display("** midi_performance_intent_tracker: PASSED **");
    end else begin
      $display("** midi_performance_intent_tracker: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** midi_performance_intent_tracker: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mpit_pkg.sv
rtl/core/mpit_ctrl.sv
rtl/core/mpit_dp.sv
rtl/core/midi_performance_intent_tracker.sv
rtl/core/mpit_checker.sv
test/mpit_checker.sv
test/tb_midi_performance_intent_tracker.sv
